[hw/rtl/snmpvb_pkg.sv]
// shared types, constants and helper functions of the varbind parser
`default_nettype none

package snmpvb_pkg;

    // default parameter values
    localparam int P_VARBIND_COUNT      = 9;
    localparam int P_MAX_DATAGRAM_BYTES = 2048;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int SLOT_W  = 4;
    localparam int VALUE_W = 32;
    localparam int LEVEL_W = 16;
    localparam int LEN_W   = 32;
    localparam int LEVELS  = 5;

    // output queue depth and its pointer and fill count widths
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // tags
    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_PDU      = 8'hA2;
    localparam logic [7:0] TAG_OCTETS   = 8'h04;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;

    // length byte fields
    localparam logic [7:0] LEN_LONG_FLAG  = 8'h80;
    localparam logic [7:0] LEN_COUNT_MASK = 8'h7F;
    localparam logic [6:0] LEN_COUNT_MAX  = 7'd4;

    // header step codes
    localparam logic [2:0] STEP_TAG        = 3'd0;
    localparam logic [2:0] STEP_LEN        = 3'd1;
    localparam logic [2:0] STEP_LONG_LAST  = 3'd2;
    localparam logic [2:0] STEP_LONG_FIRST = 3'd5;
    localparam logic [2:0] STEP_FIRST      = 3'd6;
    localparam logic [2:0] STEP_MORE       = 3'd7;

    // result kinds and status codes
    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // element being parsed
    typedef enum logic [10:0] {
        PH_OUTER     = 11'b000_0000_0001,
        PH_VERSION   = 11'b000_0000_0010,
        PH_COMMUNITY = 11'b000_0000_0100,
        PH_PDU       = 11'b000_0000_1000,
        PH_REQID     = 11'b000_0001_0000,
        PH_ERRSTAT   = 11'b000_0010_0000,
        PH_ERRINDEX  = 11'b000_0100_0000,
        PH_VBL       = 11'b000_1000_0000,
        PH_VB        = 11'b001_0000_0000,
        PH_OID       = 11'b010_0000_0000,
        PH_VALUE     = 11'b100_0000_0000
    } t_phase;

    // values handed from the parser to the output queue
    typedef struct packed {
        logic                 v_valid;
        logic [SLOT_W-1:0]    v_slot;
        logic                 v_is_float;
        logic [VALUE_W-1:0]   v_bits;
        logic                 s_valid;
        logic                 s_status;
    } t_push;

    // one result transaction
    typedef struct packed {
        logic                 kind;
        logic [SLOT_W-1:0]    slot;
        logic                 float_flag;
        logic [VALUE_W-1:0]   bits;
        logic                 status;
        logic                 last;
    } t_result;

    // nesting level that encloses each element
    function automatic logic [2:0] f_level(input t_phase ph);
        logic [2:0] lv;
        case (ph)
            PH_OUTER:                                   lv = 3'd0;
            PH_VERSION, PH_COMMUNITY, PH_PDU:           lv = 3'd1;
            PH_REQID, PH_ERRSTAT, PH_ERRINDEX, PH_VBL:  lv = 3'd2;
            PH_VB:                                      lv = 3'd3;
            PH_OID, PH_VALUE:                           lv = 3'd4;
            default:                                    lv = 3'd0;
        endcase
        return lv;
    endfunction

    // element that follows a skipped element
    function automatic t_phase f_next(input t_phase ph);
        t_phase nx;
        case (ph)
            PH_VERSION:   nx = PH_COMMUNITY;
            PH_COMMUNITY: nx = PH_PDU;
            PH_REQID:     nx = PH_ERRSTAT;
            PH_ERRSTAT:   nx = PH_ERRINDEX;
            PH_ERRINDEX:  nx = PH_VBL;
            PH_OID:       nx = PH_VALUE;
            default:      nx = ph;
        endcase
        return nx;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/snmpvb_ifs.sv]
// handshake interfaces for datagram bytes and parse results
`default_nettype none

interface snmpvb_byte_if
    import snmpvb_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_datagram;

    modport source (output valid, output data_byte, output end_of_datagram, input ready);
    modport sink   (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

interface snmpvb_result_if
    import snmpvb_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [SLOT_W-1:0]  slot_index;
    logic               value_is_float;
    logic [VALUE_W-1:0] value_bits;
    logic               parse_status;
    logic               last_in_run;

    modport source (output valid, output result_kind, output slot_index,
                    output value_is_float, output value_bits, output parse_status,
                    output last_in_run, input ready);
    modport sink   (input valid, input result_kind, input slot_index,
                    input value_is_float, input value_bits, input parse_status,
                    input last_in_run, output ready);
endinterface

`default_nettype wire

[hw/rtl/snmpvb_core.sv]
// input register and ber tlv parse state, one byte per cycle while the result queue has room
`default_nettype none

module snmpvb_core
    import snmpvb_pkg::*;
#(
    parameter int VARBIND_COUNT      = P_VARBIND_COUNT,
    parameter int MAX_DATAGRAM_BYTES = P_MAX_DATAGRAM_BYTES
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    snmpvb_byte_if.sink   i_byte,
    input  wire           i_room,
    output t_push         o_push
);

    localparam logic [LEVEL_W-1:0] LVL0_RESET = LEVEL_W'(MAX_DATAGRAM_BYTES);
    localparam logic [SLOT_W-1:0]  VB_LAST    = SLOT_W'(VARBIND_COUNT);

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_eod;
    logic              w_consume;

    // parse state
    logic [LEVEL_W-1:0] r_lvl [LEVELS];
    logic [LEVEL_W-1:0] n_lvl [LEVELS];
    t_phase             r_phase, n_phase;
    logic [2:0]         r_step, n_step;
    logic [LEN_W-1:0]   r_pend, n_pend;
    logic [7:0]         r_tag, n_tag;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [SLOT_W-1:0]  r_cnt, n_cnt;
    logic               r_complete, n_complete;
    logic               r_failed, n_failed;

    // per-byte working values
    logic [LEVEL_W-1:0] w_dec [LEVELS];
    logic [2:0]         w_c;
    logic [LEVEL_W-1:0] w_lvl_c;
    logic [LEVEL_W-1:0] w_dec_c;
    logic               w_trailing;
    logic               w_hd;
    logic [LEN_W-1:0]   w_hd_len;
    logic               w_vd;
    logic               w_vd_float;
    logic [VALUE_W-1:0] w_vd_bits;
    logic [SLOT_W-1:0]  w_cnt_inc;
    logic [LEN_W-1:0]   w_pend_dec;
    logic [VALUE_W-1:0] w_int_base;
    logic [VALUE_W-1:0] w_int_acc;
    logic [VALUE_W-1:0] w_flt_acc;
    logic [6:0]         w_len_cnt;
    logic               w_status;

    assign w_consume    = r_in_valid && i_room;
    assign i_byte.ready = !r_in_valid || i_room;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_eod  <= i_byte.end_of_datagram;
        end
    end

    // level bookkeeping
    always_comb begin
        w_c        = f_level(r_phase);
        w_trailing = 1'b0;
        for (int k = 0; k < LEVELS; k++) begin
            w_dec[k] = (r_lvl[k] != '0) ? r_lvl[k] - LEVEL_W'(1) : '0;
            if ((k > int'(w_c)) && (r_lvl[k] != '0)) begin
                w_trailing = 1'b1;
            end
        end
        case (w_c)
            3'd0:    begin w_lvl_c = r_lvl[0]; w_dec_c = w_dec[0]; end
            3'd1:    begin w_lvl_c = r_lvl[1]; w_dec_c = w_dec[1]; end
            3'd2:    begin w_lvl_c = r_lvl[2]; w_dec_c = w_dec[2]; end
            3'd3:    begin w_lvl_c = r_lvl[3]; w_dec_c = w_dec[3]; end
            3'd4:    begin w_lvl_c = r_lvl[4]; w_dec_c = w_dec[4]; end
            default: begin w_lvl_c = r_lvl[0]; w_dec_c = w_dec[0]; end
        endcase
    end

    // content arithmetic
    assign w_pend_dec = r_pend - LEN_W'(1);
    assign w_int_base = (r_step == STEP_FIRST) ? {VALUE_W{r_in_byte[7]}} : r_acc;
    assign w_int_acc  = {w_int_base[VALUE_W-9:0], r_in_byte};
    assign w_flt_acc  = {r_in_byte, r_acc[VALUE_W-1:8]};
    assign w_cnt_inc  = r_cnt + SLOT_W'(1);
    assign w_len_cnt  = r_in_byte[6:0] & LEN_COUNT_MASK[6:0];

    // next parse state
    always_comb begin
        n_lvl      = r_lvl;
        n_phase    = r_phase;
        n_step     = r_step;
        n_pend     = r_pend;
        n_tag      = r_tag;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_complete = r_complete;
        n_failed   = r_failed;
        w_hd       = 1'b0;
        w_hd_len   = '0;
        w_vd       = 1'b0;
        w_vd_float = 1'b0;
        w_vd_bits  = '0;
        w_status   = STATUS_OK;

        if (w_consume && !r_failed) begin
            if (r_complete) begin
                n_lvl = w_dec;
            end else if (!w_trailing && (w_lvl_c == '0)) begin
                n_failed = 1'b1;
            end else begin
                n_lvl = w_dec;
                if (!w_trailing) begin
                    if (r_step == STEP_TAG) begin
                        n_tag  = r_in_byte;
                        n_step = STEP_LEN;
                    end else if (r_step == STEP_LEN) begin
                        if ((r_in_byte & LEN_LONG_FLAG) != '0) begin
                            if ((w_len_cnt == '0) || (w_len_cnt > LEN_COUNT_MAX)) begin
                                n_failed = 1'b1;
                            end else begin
                                n_pend = '0;
                                n_step = STEP_LEN + w_len_cnt[2:0];
                            end
                        end else begin
                            w_hd     = 1'b1;
                            w_hd_len = LEN_W'(r_in_byte);
                        end
                    end else if (r_step inside {[STEP_LONG_LAST:STEP_LONG_FIRST]}) begin
                        n_pend = {r_pend[LEN_W-9:0], r_in_byte};
                        n_step = r_step - 3'd1;
                        if (r_step == STEP_LONG_LAST) begin
                            w_hd     = 1'b1;
                            w_hd_len = {r_pend[LEN_W-9:0], r_in_byte};
                        end
                    end else begin
                        // content byte
                        n_step = STEP_MORE;
                        n_pend = w_pend_dec;
                        if ((r_phase == PH_VALUE) && (r_tag == TAG_OCTETS)) begin
                            n_acc = w_flt_acc;
                            if (w_pend_dec == '0) begin
                                w_vd       = 1'b1;
                                w_vd_float = 1'b1;
                                w_vd_bits  = w_flt_acc;
                            end
                        end else if ((r_phase == PH_VALUE) || (r_phase == PH_ERRSTAT)) begin
                            n_acc = w_int_acc;
                            if (w_pend_dec == '0) begin
                                if (r_phase == PH_VALUE) begin
                                    w_vd      = 1'b1;
                                    w_vd_bits = w_int_acc;
                                end else if (w_int_acc != '0) begin
                                    n_failed = 1'b1;
                                end else begin
                                    n_phase = PH_ERRINDEX;
                                    n_step  = STEP_TAG;
                                end
                            end
                        end else if (w_pend_dec == '0) begin
                            n_phase = f_next(r_phase);
                            n_step  = STEP_TAG;
                        end
                    end

                    // complete header: length check and element dispatch
                    if (w_hd) begin
                        n_pend = w_hd_len;
                        if (w_hd_len > LEN_W'(w_dec_c)) begin
                            n_failed = 1'b1;
                        end else begin
                            n_acc = '0;
                            case (r_phase)
                                PH_OUTER: begin
                                    if (r_tag != TAG_SEQUENCE) n_failed = 1'b1;
                                    n_lvl[1] = w_hd_len[LEVEL_W-1:0];
                                    n_phase  = PH_VERSION;
                                    n_step   = STEP_TAG;
                                end
                                PH_PDU: begin
                                    if (r_tag != TAG_PDU) n_failed = 1'b1;
                                    n_lvl[2] = w_hd_len[LEVEL_W-1:0];
                                    n_phase  = PH_REQID;
                                    n_step   = STEP_TAG;
                                end
                                PH_VBL: begin
                                    if (r_tag != TAG_SEQUENCE) n_failed = 1'b1;
                                    n_lvl[3] = w_hd_len[LEVEL_W-1:0];
                                    n_phase  = PH_VB;
                                    n_step   = STEP_TAG;
                                end
                                PH_VB: begin
                                    if (r_tag != TAG_SEQUENCE) n_failed = 1'b1;
                                    n_lvl[4] = w_hd_len[LEVEL_W-1:0];
                                    n_phase  = PH_OID;
                                    n_step   = STEP_TAG;
                                end
                                PH_VALUE: begin
                                    if (r_tag == TAG_OCTETS) begin
                                        if (w_hd_len != LEN_W'(4)) begin
                                            w_vd       = 1'b1;
                                            w_vd_float = 1'b1;
                                        end else begin
                                            n_step = STEP_FIRST;
                                        end
                                    end else if (r_tag == TAG_INTEGER) begin
                                        if (w_hd_len == '0) w_vd = 1'b1;
                                        else n_step = STEP_FIRST;
                                    end else begin
                                        n_failed = 1'b1;
                                    end
                                end
                                default: begin
                                    // skipped elements and the error status
                                    if (w_hd_len == '0) begin
                                        n_phase = f_next(r_phase);
                                        n_step  = STEP_TAG;
                                    end else begin
                                        n_step = STEP_FIRST;
                                    end
                                end
                            endcase
                        end
                    end

                    // varbind value finished
                    if (w_vd) begin
                        n_cnt = w_cnt_inc;
                        if (w_cnt_inc >= VB_LAST) begin
                            n_complete = 1'b1;
                        end else begin
                            n_phase = PH_VB;
                            n_step  = STEP_TAG;
                        end
                    end
                end
            end
        end

        // end of datagram: report and start over
        if (w_consume && r_in_eod) begin
            w_status = (n_complete && !n_failed && (n_lvl[1] == '0)) ? STATUS_OK
                                                                        : STATUS_FAIL;
            n_lvl[0]   = LVL0_RESET;
            for (int k = 1; k < LEVELS; k++) n_lvl[k] = '0;
            n_phase    = PH_OUTER;
            n_step     = STEP_TAG;
            n_pend     = '0;
            n_tag      = '0;
            n_acc      = '0;
            n_cnt      = '0;
            n_complete = 1'b0;
            n_failed   = 1'b0;
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl[0] <= LVL0_RESET;
            for (int k = 1; k < LEVELS; k++) r_lvl[k] <= '0;
            r_phase    <= PH_OUTER;
            r_step     <= STEP_TAG;
            r_pend     <= '0;
            r_tag      <= '0;
            r_acc      <= '0;
            r_cnt      <= '0;
            r_complete <= 1'b0;
            r_failed   <= 1'b0;
        end else begin
            r_lvl      <= n_lvl;
            r_phase    <= n_phase;
            r_step     <= n_step;
            r_pend     <= n_pend;
            r_tag      <= n_tag;
            r_acc      <= n_acc;
            r_cnt      <= n_cnt;
            r_complete <= n_complete;
            r_failed   <= n_failed;
        end
    end

    // results of this byte
    always_comb begin
        o_push.v_valid    = w_consume && w_vd;
        o_push.v_slot     = r_cnt;
        o_push.v_is_float = w_vd_float;
        o_push.v_bits     = w_vd_bits;
        o_push.s_valid    = w_consume && r_in_eod;
        o_push.s_status   = w_status;
    end

    // slot numbers stay inside the varbind list
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.v_valid |-> (o_push.v_slot < VB_LAST))
        else $error("value emitted for a slot beyond the varbind count");

    // a status transaction leaves the parser in its start state
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.s_valid |=> (r_cnt == '0 && !r_failed && !r_complete &&
                            r_step == STEP_TAG && r_phase == PH_OUTER))
        else $error("parser not restarted after end of datagram");

    // nothing is decoded after a failure or after completion
    a_no_value_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_failed || r_complete) |-> !o_push.v_valid)
        else $error("value emitted after the parse ended");

endmodule

`default_nettype wire

[hw/rtl/snmpvb_outq.sv]
// result queue that takes up to two results per cycle and sends one
`default_nettype none

module snmpvb_outq
    import snmpvb_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_push            i_push,
    output logic             o_room,
    snmpvb_result_if.source  o_result
);

    t_result              r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr, r_rd;
    logic [Q_CNT_W-1:0]   r_cnt;
    logic [Q_PTR_W-1:0]   w_wr_s;
    logic [Q_CNT_W-1:0]   w_n_push;
    logic                 w_pop;
    t_result              w_val_e, w_sts_e, w_head;

    assign o_room   = (r_cnt <= Q_CNT_W'(Q_DEPTH - 2));
    assign w_pop    = o_result.valid && o_result.ready;
    assign w_n_push = Q_CNT_W'(i_push.v_valid) + Q_CNT_W'(i_push.s_valid);
    assign w_wr_s   = i_push.v_valid ? r_wr + Q_PTR_W'(1) : r_wr;

    // entries built from the parser outputs
    always_comb begin
        w_val_e.kind       = KIND_VALUE;
        w_val_e.slot       = i_push.v_slot;
        w_val_e.float_flag = i_push.v_is_float;
        w_val_e.bits       = i_push.v_bits;
        w_val_e.status     = STATUS_OK;
        w_val_e.last       = !i_push.s_valid;
        w_sts_e.kind       = KIND_STATUS;
        w_sts_e.slot       = '0;
        w_sts_e.float_flag = 1'b0;
        w_sts_e.bits       = '0;
        w_sts_e.status     = i_push.s_status;
        w_sts_e.last       = 1'b1;
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.v_valid) r_q[r_wr]   <= w_val_e;
        if (i_push.s_valid) r_q[w_wr_s] <= w_sts_e;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + Q_PTR_W'(w_n_push);
            r_rd  <= r_rd + Q_PTR_W'(w_pop);
            r_cnt <= r_cnt + w_n_push - Q_CNT_W'(w_pop);
        end
    end

    // head of queue to the port
    assign w_head                  = r_q[r_rd];
    assign o_result.valid          = (r_cnt != '0);
    assign o_result.result_kind    = w_head.kind;
    assign o_result.slot_index     = w_head.slot;
    assign o_result.value_is_float = w_head.float_flag;
    assign o_result.value_bits     = w_head.bits;
    assign o_result.parse_status   = w_head.status;
    assign o_result.last_in_run    = w_head.last;

    // fill count never exceeds the depth
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    // the parser only pushes when room for two was offered
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.v_valid || i_push.s_valid) |-> o_room)
        else $error("results pushed without room");

    // a lone pop lowers the fill count by one
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !i_push.v_valid && !i_push.s_valid) |=>
            (r_cnt == $past(r_cnt) - Q_CNT_W'(1)))
        else $error("fill count wrong after pop");

endmodule

`default_nettype wire

[hw/rtl/snmp_response_varbind_parser_unit.sv]
// Top level of the SNMP GetResponse varbind parser.
// A byte accepted is held in the input register and parsed from there; its results
// are written into the result queue and are offered on the output port from it.
// Throughput: one byte per cycle while the queue has room; a byte that ends a varbind value
// and the datagram gives two results, which leave the four-entry result queue one per cycle.
// Reset (i_rst_n low, synchronous) empties both registers and queue and restarts the parse.
`default_nettype none

module snmp_response_varbind_parser_unit
    import snmpvb_pkg::*;
#(
    parameter int VARBIND_COUNT      = P_VARBIND_COUNT,
    parameter int MAX_DATAGRAM_BYTES = P_MAX_DATAGRAM_BYTES
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    snmpvb_byte_if.sink      i_byte,
    snmpvb_result_if.source  o_result
);

    t_push w_push;
    logic  w_room;

    // byte parser
    snmpvb_core #(
        .VARBIND_COUNT      (VARBIND_COUNT),
        .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_room  (w_room),
        .o_push  (w_push)
    );

    // result queue
    snmpvb_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_room   (w_room),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
